>>> src/itoa_pkg.sv
`default_nettype none

package itoa_pkg;

    // Width of the pointer operand taken from the value field.
    localparam int VALUE_WIDTH = 64;
    localparam logic [63:0] PTR_MASK = {64{1'b1}} >> (64 - VALUE_WIDTH);

    // Saturation point of the running character total.
    localparam logic [30:0] TOTAL_MAX = {31{1'b1}};

    // Double-dabble runs one step per magnitude bit.
    localparam logic [4:0] DABBLE_LAST = 5'd31;
    localparam logic [3:0] NIB_TOP = 4'd15;

    // Conversion selectors.
    typedef enum logic [2:0] {
        CMD_SDEC = 3'd0,
        CMD_UDEC = 3'd1,
        CMD_HEXL = 3'd2,
        CMD_HEXU = 3'd3,
        CMD_PTR  = 3'd4
    } cmd_t;

    // Micro-operations of the sequencer.
    typedef enum logic [1:0] {
        UOP_ACCEPT = 2'd0,
        UOP_EMIT   = 2'd1,
        UOP_DABBLE = 2'd2,
        UOP_SCAN   = 2'd3
    } uop_t;

    // Program addresses.
    localparam logic [3:0] PC_IDLE    = 4'd0;
    localparam logic [3:0] PC_SIGN    = 4'd1;
    localparam logic [3:0] PC_DABBLE  = 4'd2;
    localparam logic [3:0] PC_SCAN_LO = 4'd3;
    localparam logic [3:0] PC_SCAN_UP = 4'd4;
    localparam logic [3:0] PC_PFX_0   = 4'd5;
    localparam logic [3:0] PC_PFX_X   = 4'd6;
    localparam logic [3:0] PC_NIL     = 4'd8;

    // One control word of the program.
    typedef struct packed {
        uop_t       op;
        logic [7:0] chr;
        logic       last;
        logic       upper;
        logic [3:0] target;
    } uword_t;

    // Controls from the sequencer to the datapath.
    typedef struct packed {
        logic       load;
        logic       dabble;
        logic       shift;
        logic       emit;
        logic       from_nib;
        logic       upper;
        logic [7:0] chr;
        logic       last;
    } dp_ctrl_t;

    // Status from the datapath to the sequencer.
    typedef struct packed {
        logic [2:0] in_cmd;
        logic       in_neg;
        logic       in_ptr_zero;
        logic       out_free;
        logic       cnt_zero;
        logic       idx_zero;
        logic       nib_zero;
        logic       started;
    } dp_stat_t;

    // The microprogram ROM.
    function automatic uword_t ucode(input logic [3:0] pc);
        uword_t w;
        w = '{op: UOP_ACCEPT, chr: 8'h00, last: 1'b0, upper: 1'b0, target: PC_IDLE};
        unique case (pc)
            4'd1:    w = '{op: UOP_EMIT,   chr: "-", last: 1'b0, upper: 1'b0,
                           target: PC_DABBLE};
            4'd2:    w = '{op: UOP_DABBLE, chr: 8'h00, last: 1'b0, upper: 1'b0,
                           target: PC_SCAN_LO};
            4'd3:    w = '{op: UOP_SCAN,   chr: 8'h00, last: 1'b0, upper: 1'b0,
                           target: PC_IDLE};
            4'd4:    w = '{op: UOP_SCAN,   chr: 8'h00, last: 1'b0, upper: 1'b1,
                           target: PC_IDLE};
            4'd5:    w = '{op: UOP_EMIT,   chr: "0", last: 1'b0, upper: 1'b0,
                           target: PC_PFX_X};
            4'd6:    w = '{op: UOP_EMIT,   chr: "x", last: 1'b0, upper: 1'b0,
                           target: PC_SCAN_LO};
            4'd8:    w = '{op: UOP_EMIT,   chr: "(", last: 1'b0, upper: 1'b0,
                           target: 4'd9};
            4'd9:    w = '{op: UOP_EMIT,   chr: "n", last: 1'b0, upper: 1'b0,
                           target: 4'd10};
            4'd10:   w = '{op: UOP_EMIT,   chr: "i", last: 1'b0, upper: 1'b0,
                           target: 4'd11};
            4'd11:   w = '{op: UOP_EMIT,   chr: "l", last: 1'b0, upper: 1'b0,
                           target: 4'd12};
            4'd12:   w = '{op: UOP_EMIT,   chr: ")", last: 1'b1, upper: 1'b0,
                           target: PC_IDLE};
            default: w = '{op: UOP_ACCEPT, chr: 8'h00, last: 1'b0, upper: 1'b0,
                           target: PC_IDLE};
        endcase
        return w;
    endfunction

    // ASCII digit for one nibble.
    function automatic logic [7:0] hex_char(input logic [3:0] nib, input logic upper);
        logic [7:0] c;
        if (nib < 4'd10) begin
            c = 8'("0") + {4'd0, nib};
        end else begin
            c = (upper ? 8'("A") : 8'("a")) + {4'd0, nib} - 8'd10;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

>>> src/itoa_useq.sv
`default_nettype none

module itoa_useq (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire itoa_pkg::dp_stat_t  stat,
    output itoa_pkg::dp_ctrl_t       ctrl
);
    import itoa_pkg::*;

    logic [3:0] pc_reg;
    logic [3:0] pc_next;
    uword_t     uw;

    // Step counter.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= PC_IDLE;
        end else begin
            pc_reg <= pc_next;
        end
    end

    assign uw = ucode(pc_reg);

    // Decode the control word and pick the next step.
    always_comb begin
        ctrl     = '0;
        s_tready = 1'b0;
        pc_next  = pc_reg;
        unique case (uw.op)
            UOP_ACCEPT: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    ctrl.load = 1'b1;
                    case (stat.in_cmd)
                        CMD_SDEC: pc_next = stat.in_neg ? PC_SIGN : PC_DABBLE;
                        CMD_UDEC: pc_next = PC_DABBLE;
                        CMD_HEXL: pc_next = PC_SCAN_LO;
                        CMD_HEXU: pc_next = PC_SCAN_UP;
                        CMD_PTR:  pc_next = stat.in_ptr_zero ? PC_NIL : PC_PFX_0;
                        default:  pc_next = PC_IDLE;
                    endcase
                end
            end
            UOP_EMIT: begin
                ctrl.chr  = uw.chr;
                ctrl.last = uw.last;
                if (stat.out_free) begin
                    ctrl.emit = 1'b1;
                    pc_next   = uw.target;
                end
            end
            UOP_DABBLE: begin
                ctrl.dabble = 1'b1;
                if (stat.cnt_zero) begin
                    pc_next = uw.target;
                end
            end
            UOP_SCAN: begin
                ctrl.from_nib = 1'b1;
                ctrl.upper    = uw.upper;
                ctrl.last     = stat.idx_zero;
                // Leading zero nibbles are dropped without using the output.
                if (stat.nib_zero && !stat.started && !stat.idx_zero) begin
                    ctrl.shift = 1'b1;
                end else if (stat.out_free) begin
                    ctrl.shift = 1'b1;
                    ctrl.emit  = 1'b1;
                    if (stat.idx_zero) begin
                        pc_next = uw.target;
                    end
                end
            end
            default: pc_next = PC_IDLE;
        endcase
    end

endmodule

`default_nettype wire

>>> src/itoa_dp.sv
`default_nettype none

module itoa_dp (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic [71:0]         s_tdata,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [39:0]              m_tdata,
    output logic                     m_tlast,
    input  wire itoa_pkg::dp_ctrl_t  ctrl,
    output itoa_pkg::dp_stat_t       stat
);
    import itoa_pkg::*;

    logic [2:0]  in_cmd;
    logic [63:0] in_value;
    logic [31:0] in_lo;

    logic [63:0] nib_reg, nib_next;
    logic [31:0] bin_reg, bin_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [3:0]  idx_reg, idx_next;
    logic        started_reg, started_next;
    logic [63:0] nib_adj;

    logic        valid_reg, valid_next;
    logic [7:0]  ch_reg, ch_next;
    logic        last_reg, last_next;
    logic [30:0] total_reg, total_next;

    assign in_cmd   = s_tdata[2:0];
    assign in_value = s_tdata[66:3];
    assign in_lo    = in_value[31:0];

    // Status for the sequencer.
    always_comb begin
        stat.in_cmd      = in_cmd;
        stat.in_neg      = in_lo[31];
        stat.in_ptr_zero = (in_value & PTR_MASK) == 64'd0;
        stat.out_free    = !valid_reg || m_tready;
        stat.cnt_zero    = cnt_reg == 5'd0;
        stat.idx_zero    = idx_reg == 4'd0;
        stat.nib_zero    = nib_reg[63:60] == 4'd0;
        stat.started     = started_reg;
    end

    // Add three to every BCD digit of five or more before the shift.
    always_comb begin
        for (int i = 0; i < 16; i++) begin
            nib_adj[i*4 +: 4] = (nib_reg[i*4 +: 4] >= 4'd5) ?
                                nib_reg[i*4 +: 4] + 4'd3 : nib_reg[i*4 +: 4];
        end
    end

    // Digit register, binary magnitude and loop counters.
    always_comb begin
        nib_next     = nib_reg;
        bin_next     = bin_reg;
        cnt_next     = cnt_reg;
        idx_next     = idx_reg;
        started_next = started_reg;
        if (ctrl.load) begin
            case (in_cmd)
                CMD_HEXL, CMD_HEXU: nib_next = {32'd0, in_lo};
                CMD_PTR:            nib_next = in_value & PTR_MASK;
                default:            nib_next = 64'd0;
            endcase
            bin_next     = (in_cmd == CMD_SDEC && in_lo[31]) ? (~in_lo) + 32'd1 : in_lo;
            cnt_next     = DABBLE_LAST;
            idx_next     = NIB_TOP;
            started_next = 1'b0;
        end else if (ctrl.dabble) begin
            nib_next = {nib_adj[62:0], bin_reg[31]};
            bin_next = {bin_reg[30:0], 1'b0};
            cnt_next = cnt_reg - 5'd1;
        end else if (ctrl.shift) begin
            nib_next = {nib_reg[59:0], 4'd0};
            idx_next = idx_reg - 4'd1;
            if (ctrl.emit) begin
                started_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        nib_reg     <= nib_next;
        bin_reg     <= bin_next;
        cnt_reg     <= cnt_next;
        idx_reg     <= idx_next;
        started_reg <= started_next;
    end

    // Output register and running character total.
    always_comb begin
        valid_next = valid_reg;
        ch_next    = ch_reg;
        last_next  = last_reg;
        total_next = total_reg;
        if (ctrl.emit) begin
            valid_next = 1'b1;
            ch_next    = ctrl.from_nib ? hex_char(nib_reg[63:60], ctrl.upper) : ctrl.chr;
            last_next  = ctrl.last;
            if (total_reg != TOTAL_MAX) begin
                total_next = total_reg + 31'd1;
            end
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            total_reg <= 31'd0;
        end else begin
            valid_reg <= valid_next;
            total_reg <= total_next;
        end
        ch_reg   <= ch_next;
        last_reg <= last_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {1'b0, total_reg, ch_reg};
    assign m_tlast  = last_reg;

endmodule

`default_nettype wire

>>> src/integer_to_ascii_formatter.sv
// Integer to ASCII formatter.
// Input channel s_*: one request per item, s_tdata = {pad, value[63:0], cmd[2:0]}.
// cmd selects signed decimal, unsigned decimal, lower hex, upper hex or pointer.
// Output channel m_*: one character per item, m_tdata = {pad, total_chars, ch},
// m_tlast marks the final character of a request.
// One request is worked on at a time; s_tready is high only at the idle step.
// After the accept, a negative signed decimal request emits a minus sign; decimal
// requests then run 32 double-dabble steps and a 16-step nibble scan.
// Hex requests run the nibble scan alone, pointers emit 0x before it, and a null pointer emits (nil).
// Leading zero nibbles are scanned without output.
// A character waits in the output register while the next step keeps working;
// a stalled receiver holds the sequencer only at its next character.
// Unused selectors are taken and dropped.
// Reset clears the program counter, the output valid and the character total.
`default_nettype none

module integer_to_ascii_formatter (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [71:0] s_tdata,   // cmd[2:0], value[66:3], zero pad
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // ch[7:0], total_chars[38:8], zero pad
    output logic             m_tlast
);
    import itoa_pkg::*;

    dp_ctrl_t ctrl;
    dp_stat_t stat;

    // Microprogram sequencer.
    itoa_useq u_useq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .ctrl     (ctrl)
    );

    // Digit datapath and output register.
    itoa_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .ctrl     (ctrl),
        .stat     (stat)
    );

endmodule

`default_nettype wire

>>> src/itoa_checker.sv
`default_nettype none

module itoa_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [71:0] s_tdata,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [39:0] m_tdata,
    input wire logic        m_tlast
);

    // A stalled character holds its value.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled output changed");

    // Reset empties the output register.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    // An accepted request with a used selector keeps the block busy for at least the next cycle.
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (!s_tdata[2] || s_tdata[2:0] == 3'd4) |=> !s_tready)
        else $error("request taken while busy");

    // While a character other than the final one waits, the conversion is not done.
    a_mid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("request taken mid conversion");

    // Every character counts itself in the total.
    a_total: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[38:8] != 31'd0)
        else $error("character total is zero");

endmodule

bind integer_to_ascii_formatter itoa_checker u_itoa_checker (.*);

`default_nettype wire
